// File: hdl/atan2pa_pkg.sv
// ----------------------------------------------------------------------------
// atan2pa_pkg
// Shared widths, constants and pipeline word types for the atan2 core.
// ----------------------------------------------------------------------------
`default_nettype none

package atan2pa_pkg;

    // Field widths
    localparam int IN_WIDTH        = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int OUT_WIDTH       = ANGLE_FRAC_BITS + 3;

    // Magnitude of an input component, up to 2^(IN_WIDTH-1)
    localparam int MAG_WIDTH = IN_WIDTH;

    // Ratio u in Q1.15
    localparam int U_FRAC    = 15;
    localparam int U_WIDTH   = U_FRAC + 1;
    localparam int DIV_STEPS = U_WIDTH;
    localparam int REM_WIDTH = MAG_WIDTH + 1;
    localparam int NUM_WIDTH = MAG_WIDTH + U_WIDTH;

    localparam logic [U_WIDTH-1:0] ONE_Q15 = U_WIDTH'(32'd1 << U_FRAC);

    // Polynomial term widths
    localparam int QUAD_W = 2 * U_FRAC - 1;
    localparam int LIN2_W = 29;
    localparam int PROD_W = QUAD_W + LIN2_W;

    localparam logic [LIN2_W-1:0] COEF_A_Q15 = LIN2_W'(8018);
    localparam logic [LIN2_W-1:0] COEF_B_Q15 = LIN2_W'(2173);
    localparam logic [LIN2_W-1:0] LIN2_BASE  = COEF_A_Q15 << U_FRAC;

    // Angle arithmetic in Q60, signed 64-bit
    localparam int A_W = 64;
    localparam logic signed [A_W-1:0] PI_Q60      = 64'sh3243F6A8885A308D;
    localparam logic signed [A_W-1:0] HALF_PI_Q60 = 64'sh1921FB54442D1846;

    // pi/4 in Q45, split into two partial products
    localparam int PI4_WIDTH = 45;
    localparam int PI4_LO_W  = 23;
    localparam int PI4_HI_W  = PI4_WIDTH - PI4_LO_W;
    localparam logic [PI4_WIDTH-1:0] PI4_Q45 = PI4_WIDTH'(PI_Q60 >> 17);
    localparam logic [PI4_LO_W-1:0]  PI4_LO  = PI4_Q45[PI4_LO_W-1:0];
    localparam logic [PI4_HI_W-1:0]  PI4_HI  = PI4_Q45[PI4_WIDTH-1:PI4_LO_W];

    localparam int LIN_LO_W = U_WIDTH + PI4_LO_W;
    localparam int LIN_HI_W = U_WIDTH + PI4_HI_W;
    localparam int G_W      = U_WIDTH + PI4_WIDTH;

    // Output rounding and saturation
    localparam int ROUND_SHIFT = 60 - ANGLE_FRAC_BITS;
    localparam int Q_WIDTH     = ANGLE_FRAC_BITS + 4;
    localparam int QM_W        = ANGLE_FRAC_BITS + 2;
    localparam logic [A_W-1:0] ROUND_HALF = A_W'(1) << (ROUND_SHIFT - 1);
    localparam logic [A_W-1:0] PI_RND     = (PI_Q60 + ROUND_HALF) >> ROUND_SHIFT;
    localparam logic [QM_W-1:0] PI_OUT    = QM_W'(PI_RND);

    // Quadrant information carried along the pipe
    typedef struct packed {
        logic x_zero;
        logic y_pos;
        logic y_neg;
        logic x_neg;
        logic y_lt_x;
    } t_flags;

    // One divider stage word
    typedef struct packed {
        logic [REM_WIDTH-1:0] rem;
        logic [REM_WIDTH-1:0] den;
        logic [U_WIDTH-1:0]   low;
        logic [U_WIDTH-1:0]   q;
        t_flags               flags;
    } t_div;

endpackage

`default_nettype wire

// File: hdl/atan2_polynomial_approx_core.sv
// ----------------------------------------------------------------------------
// atan2_polynomial_approx_core
// Pipeline: 1 prep, 16 divider, 3 polynomial and 5 fix-up/round/output
//   stages between input accept and output word.
// Throughput: one word per cycle while the sink does not stall; the 16-stage
//   ratio divider is fully pipelined, so every stage takes a new word each cycle.
// Reset: synchronous, active low; clears all stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module atan2_polynomial_approx_core (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    // input channel
    input  wire logic                                        i_valid,
    output logic                                             o_stall,
    input  wire logic signed [atan2pa_pkg::IN_WIDTH-1:0]     i_y,
    input  wire logic signed [atan2pa_pkg::IN_WIDTH-1:0]     i_x,
    // output channel
    output logic                                             o_valid,
    input  wire logic                                        i_stall,
    output logic signed [atan2pa_pkg::OUT_WIDTH-1:0]         o_angle
);
    import atan2pa_pkg::*;

    // Pipeline advance. The whole pipe moves together; it only freezes
    // when the output register holds a word the sink refuses. Frozen
    // stages hold payload and valid, so nothing is dropped or repeated.
    logic en;

    logic               prep_valid;
    t_div               prep_st;
    logic               div_valid;
    logic [U_WIDTH-1:0] div_q;
    t_flags             div_flags;
    logic               poly_valid;
    logic [G_W-1:0]     poly_g;
    t_flags             poly_flags;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Magnitudes, octant flags and divider seed (lo*2^16 + hi, 2*hi)
    atan2pa_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_y     (i_y),
        .i_x     (i_x),
        .o_valid (prep_valid),
        .o_st    (prep_st)
    );

    // Ratio u = min/max in Q1.15, one quotient bit per stage
    atan2pa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prep_valid),
        .i_st    (prep_st),
        .o_valid (div_valid),
        .o_q     (div_q),
        .o_flags (div_flags)
    );

    // Arctangent polynomial on [0,1], exact in Q60
    atan2pa_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_q     (div_q),
        .i_flags (div_flags),
        .o_valid (poly_valid),
        .o_g     (poly_g),
        .o_flags (poly_flags)
    );

    // Sign/quadrant, x-zero cases, rounding, clip to +-pi, output register
    atan2pa_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (poly_valid),
        .i_g     (poly_g),
        .i_flags (poly_flags),
        .o_valid (o_valid),
        .o_angle (o_angle)
    );

endmodule

`default_nettype wire

// File: hdl/atan2pa_prep.sv
// ----------------------------------------------------------------------------
// atan2pa_prep
// Input stage: magnitudes, ordering, quadrant flags and divider seed.
// ----------------------------------------------------------------------------
`default_nettype none

module atan2pa_prep (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_en,
    input  wire logic                                        i_valid,
    input  wire logic signed [atan2pa_pkg::IN_WIDTH-1:0]     i_y,
    input  wire logic signed [atan2pa_pkg::IN_WIDTH-1:0]     i_x,
    output logic                                             o_valid,
    output atan2pa_pkg::t_div                                o_st
);
    import atan2pa_pkg::*;

    logic [MAG_WIDTH-1:0] ay;
    logic [MAG_WIDTH-1:0] ax;
    logic [MAG_WIDTH-1:0] lo;
    logic [MAG_WIDTH-1:0] hi;
    logic [NUM_WIDTH-1:0] num;
    logic                 y_lt_x;
    t_div                 n_st;
    logic                 r_valid;
    t_div                 r_st;

    // two's complement magnitude; most negative value maps to 2^(W-1)
    assign ay     = i_y[IN_WIDTH-1] ? (~i_y + 1'b1) : i_y;
    assign ax     = i_x[IN_WIDTH-1] ? (~i_x + 1'b1) : i_x;
    assign y_lt_x = ay < ax;
    assign lo     = y_lt_x ? ay : ax;
    assign hi     = y_lt_x ? ax : ay;

    // numerator lo*2^16 + hi gives round-half-up of lo/hi in Q1.15
    assign num = {lo, {U_WIDTH{1'b0}}} + hi;

    always_comb begin
        n_st              = '0;
        n_st.rem          = {1'b0, num[NUM_WIDTH-1:U_WIDTH]};
        n_st.den          = {hi, 1'b0};
        n_st.low          = num[U_WIDTH-1:0];
        n_st.q            = '0;
        n_st.flags.x_zero = (ax == '0);
        n_st.flags.y_pos  = !i_y[IN_WIDTH-1] && (i_y != '0);
        n_st.flags.y_neg  = i_y[IN_WIDTH-1];
        n_st.flags.x_neg  = i_x[IN_WIDTH-1];
        n_st.flags.y_lt_x = y_lt_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;

endmodule

`default_nettype wire

// File: hdl/atan2pa_div.sv
// ----------------------------------------------------------------------------
// atan2pa_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module atan2pa_div (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire atan2pa_pkg::t_div                     i_st,
    output logic                                       o_valid,
    output logic [atan2pa_pkg::U_WIDTH-1:0]            o_q,
    output atan2pa_pkg::t_flags                        o_flags
);
    import atan2pa_pkg::*;

    logic [DIV_STEPS-1:0] r_valid;
    t_div                 r_st [DIV_STEPS];

    // shift in one numerator bit, subtract divisor if it fits
    function automatic t_div div_step(input t_div s);
        logic [REM_WIDTH:0] trial;
        logic [REM_WIDTH:0] diff;
        t_div               res;
        trial   = {s.rem, s.low[U_WIDTH-1]};
        diff    = trial - {1'b0, s.den};
        res     = s;
        res.low = {s.low[U_WIDTH-2:0], 1'b0};
        res.q   = {s.q[U_WIDTH-2:0], ~diff[REM_WIDTH]};
        res.rem = diff[REM_WIDTH] ? trial[REM_WIDTH-1:0] : diff[REM_WIDTH-1:0];
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DIV_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= div_step(i_st);
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_st[k] <= div_step(r_st[k-1]);
            end
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_q     = r_st[DIV_STEPS-1].q;
    assign o_flags = r_st[DIV_STEPS-1].flags;

endmodule

`default_nettype wire

// File: hdl/atan2pa_poly.sv
// ----------------------------------------------------------------------------
// atan2pa_poly
// g(u) = (pi/4)u + u(1-u)(A + B*u) in Q60, three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module atan2pa_poly (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic [atan2pa_pkg::U_WIDTH-1:0]       i_q,
    input  wire atan2pa_pkg::t_flags                   i_flags,
    output logic                                       o_valid,
    output logic [atan2pa_pkg::G_W-1:0]                o_g,
    output atan2pa_pkg::t_flags                        o_flags
);
    import atan2pa_pkg::*;

    logic [U_WIDTH-1:0]   u;
    logic [2*U_WIDTH-1:0] quad_full;
    logic [LIN2_W-1:0]    n_lin2;
    logic [LIN_LO_W-1:0]  n_lin_lo;
    logic [LIN_HI_W-1:0]  n_lin_hi;
    logic [PROD_W-1:0]    n_prod;
    logic [G_W-1:0]       n_lin;
    logic [G_W-1:0]       n_g;

    logic [2:0]           r_valid;
    logic [QUAD_W-1:0]    r_quad;
    logic [LIN2_W-1:0]    r_lin2;
    logic [LIN_LO_W-1:0]  r_lin_lo;
    logic [LIN_HI_W-1:0]  r_lin_hi;
    t_flags               r_flags1;
    logic [PROD_W-1:0]    r_prod;
    logic [G_W-1:0]       r_lin;
    t_flags               r_flags2;
    logic [G_W-1:0]       r_g;
    t_flags               r_flags3;

    // stage 1: clamp, u(1-u), linear coefficient, pi/4 partial products
    assign u         = (i_q > ONE_Q15) ? ONE_Q15 : i_q;
    assign quad_full = u * (ONE_Q15 - u);
    assign n_lin2    = LIN2_BASE + COEF_B_Q15 * u;
    assign n_lin_lo  = u * PI4_LO;
    assign n_lin_hi  = u * PI4_HI;

    // stage 2: cubic product, recombine linear term
    assign n_prod = r_quad * r_lin2;
    assign n_lin  = {r_lin_hi, {PI4_LO_W{1'b0}}} + r_lin_lo;

    // stage 3: sum
    assign n_g = r_lin + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quad   <= quad_full[QUAD_W-1:0];
            r_lin2   <= n_lin2;
            r_lin_lo <= n_lin_lo;
            r_lin_hi <= n_lin_hi;
            r_flags1 <= i_flags;
            r_prod   <= n_prod;
            r_lin    <= n_lin;
            r_flags2 <= r_flags1;
            r_g      <= n_g;
            r_flags3 <= r_flags2;
        end
    end

    assign o_valid = r_valid[2];
    assign o_g     = r_g;
    assign o_flags = r_flags3;

endmodule

`default_nettype wire

// File: hdl/atan2pa_post.sv
// ----------------------------------------------------------------------------
// atan2pa_post
// Sign and quadrant fix-up, rounding, saturation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module atan2pa_post (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic [atan2pa_pkg::G_W-1:0]           i_g,
    input  wire atan2pa_pkg::t_flags                   i_flags,
    output logic                                       o_valid,
    output logic signed [atan2pa_pkg::OUT_WIDTH-1:0]   o_angle
);
    import atan2pa_pkg::*;

    logic signed [A_W-1:0] g_ext;
    logic signed [A_W-1:0] n_gs;
    logic signed [A_W-1:0] off;
    logic signed [A_W-1:0] n_a;
    logic [A_W-1:0]        n_mag;
    logic [A_W-1:0]        rnd_sum;
    logic [Q_WIDTH-1:0]    q_full;
    logic [QM_W-1:0]       n_q;
    logic [OUT_WIDTH-1:0]  q_ext;
    logic [OUT_WIDTH-1:0]  n_angle;

    logic [4:0]            r_valid;
    logic signed [A_W-1:0] r_gs;
    t_flags                r_flags;
    logic signed [A_W-1:0] r_a;
    logic [A_W-1:0]        r_mag;
    logic                  r_neg1;
    logic [QM_W-1:0]       r_q;
    logic                  r_neg2;
    logic [OUT_WIDTH-1:0]  r_angle;

    // stage 1: sign of z = y/x
    assign g_ext = {{(A_W - G_W){1'b0}}, i_g};
    assign n_gs  = (i_flags.y_neg ^ i_flags.x_neg) ? -g_ext : g_ext;

    // stage 2: quadrant
    always_comb begin
        off = '0;
        n_a = '0;
        if (r_flags.x_zero) begin
            if (r_flags.y_pos) begin
                n_a = HALF_PI_Q60;
            end else if (r_flags.y_neg) begin
                n_a = -HALF_PI_Q60;
            end
        end else if (r_flags.y_lt_x) begin
            if (r_flags.x_neg) begin
                off = r_flags.y_neg ? -PI_Q60 : PI_Q60;
            end
            n_a = off + r_gs;
        end else begin
            off = r_flags.y_neg ? (HALF_PI_Q60 - PI_Q60) : HALF_PI_Q60;
            n_a = off - r_gs;
        end
    end

    // stage 3: magnitude
    assign n_mag = r_a[A_W-1] ? -r_a : r_a;

    // stage 4: round half away from zero, clip to pi
    assign rnd_sum = r_mag + ROUND_HALF;
    assign q_full  = rnd_sum[ROUND_SHIFT +: Q_WIDTH];
    assign n_q     = (q_full > PI_OUT) ? PI_OUT : q_full[QM_W-1:0];

    // stage 5: restore sign
    assign q_ext   = {1'b0, r_q};
    assign n_angle = r_neg2 ? -q_ext : q_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gs    <= n_gs;
            r_flags <= i_flags;
            r_a     <= n_a;
            r_mag   <= n_mag;
            r_neg1  <= r_a[A_W-1];
            r_q     <= n_q;
            r_neg2  <= r_neg1;
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_valid[4];
    assign o_angle = r_angle;

endmodule

`default_nettype wire

// File: verif/atan2_polynomial_approx_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atan2_polynomial_approx_core_tb
// Self-checking bench for the atan2 core: drives (y, x) words through the
// valid/stall input channel, predicts each angle with an independent Q60
// model and compares every output word in order.
// ----------------------------------------------------------------------------

module atan2_polynomial_approx_core_tb;

    localparam int IW   = atan2pa_pkg::IN_WIDTH;
    localparam int OW   = atan2pa_pkg::OUT_WIDTH;
    localparam int FRAC = atan2pa_pkg::ANGLE_FRAC_BITS;

    // Pipe depth in stages (25, summed from the header) plus margin for the tail
    localparam int PIPE_DEPTH = 25;
    localparam int TAIL_WAIT  = PIPE_DEPTH + 15;
    localparam int DRAIN_MAX  = 5000;

    // Angle constants in Q60; pi/4 in Q45 is pi truncated by 17 bits
    localparam logic signed [63:0] PI_FULL   = 64'sh3243F6A8885A308D;
    localparam logic signed [63:0] PI_HALF   = 64'sh1921FB54442D1846;
    localparam logic [63:0]        PI4_Q45   = 64'(PI_FULL) >> 17;
    localparam logic [63:0]        UNITY_Q15 = 64'd32768;
    localparam logic [63:0]        COEF_LIN  = 64'd8018;   // 0.2447 in Q0.15
    localparam logic [63:0]        COEF_SLP  = 64'd2173;   // 0.0663 in Q0.15
    localparam int                 DROP_BITS = 60 - FRAC;
    localparam logic [63:0]        HALF_LSB  = 64'd1 << (DROP_BITS - 1);
    localparam logic [63:0]        PI_LIMIT  = (64'(PI_FULL) + HALF_LSB) >> DROP_BITS;

    typedef struct {
        logic signed [IW-1:0] y;
        logic signed [IW-1:0] x;
        logic signed [OW-1:0] angle;
    } t_angle_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [IW-1:0] i_y;
    logic signed [IW-1:0] i_x;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [OW-1:0] o_angle;

    t_angle_item pending_angles[$];   // predicted angles, oldest first
    int unsigned mismatch_count = 0;
    int unsigned stall_left     = 0;  // cycles left in current output stall burst
    bit          idling_on      = 1'b0;

    atan2_polynomial_approx_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_y     (i_y),
        .i_x     (i_x),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_angle (o_angle)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Angle of (y, x): ratio of min/max magnitude in Q1.15, polynomial in
    // Q60, quadrant fix-up, round half away from zero, clamp to +-pi.
    function automatic logic signed [OW-1:0] predict_angle(
        input logic signed [IW-1:0] y,
        input logic signed [IW-1:0] x
    );
        longint             ys, xs;
        logic [63:0]        ay, ax, lo, hi, ratio, poly, mag, q;
        logic signed [63:0] g, a;
        logic               y_neg, x_neg;
        ys    = y;
        xs    = x;
        y_neg = ys < 0;
        x_neg = xs < 0;
        ay    = y_neg ? -ys : ys;   // 2^15 for the most negative input
        ax    = x_neg ? -xs : xs;
        if (ax == 0) begin
            // vertical axis: +pi/2, -pi/2, or 0 for the zero vector
            a = (ys > 0) ? PI_HALF : (y_neg ? -PI_HALF : 64'sd0);
        end else begin
            lo    = (ay < ax) ? ay : ax;
            hi    = (ay < ax) ? ax : ay;
            // rounded ratio, ties go up
            ratio = ((lo << 16) + hi) / (hi << 1);
            if (ratio > UNITY_Q15)
                ratio = UNITY_Q15;
            poly = ratio * PI4_Q45
                 + ratio * (UNITY_Q15 - ratio) * (COEF_LIN * UNITY_Q15 + COEF_SLP * ratio);
            g = (y_neg != x_neg) ? -poly : poly;
            if (ay < ax) begin
                a = g;
                if (x_neg)
                    a = y_neg ? a - PI_FULL : a + PI_FULL;
            end else begin
                // steep side, equal magnitudes included
                a = PI_HALF - g;
                if (y_neg)
                    a = a - PI_FULL;
            end
        end
        mag = (a < 0) ? -a : a;
        q   = (mag + HALF_LSB) >> DROP_BITS;
        if (q > PI_LIMIT)
            q = PI_LIMIT;
        if (a < 0)
            q = -q;
        return q[OW-1:0];
    endfunction

    // Mix of zeros, small values, extremes and full-range values
    function automatic logic signed [IW-1:0] random_component();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return IW'(int'($urandom_range(0, 32)) - 16);
            2: begin
                case ($urandom_range(0, 5))
                    0: return {1'b1, {(IW-1){1'b0}}};
                    1: return {1'b1, {(IW-2){1'b0}}, 1'b1};
                    2: return {1'b0, {(IW-1){1'b1}}};
                    3: return {1'b0, {(IW-2){1'b1}}, 1'b0};
                    4: return '1;
                    default: return IW'(1);
                endcase
            end
            default: return IW'($urandom());
        endcase
    endfunction

    // Present one word, hold it until accepted, then log its angle.
    // Valid stays high between back-to-back words.
    task automatic send_vector(input logic signed [IW-1:0] y, input logic signed [IW-1:0] x);
        t_angle_item item;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_y     <= y;
        i_x     <= x;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        item.y     = y;
        item.x     = x;
        item.angle = predict_angle(y, x);
        pending_angles.push_back(item);
    endtask

    task automatic wait_all_angles();
        while (pending_angles.size() != 0) @(posedge i_clk);
    endtask

    // Axes, zero vector, most negative inputs, diagonals, each quadrant
    task automatic test_directed();
        send_vector(16'sd0, 16'sd0);
        send_vector(16'sd1, 16'sd0);
        send_vector(-16'sd1, 16'sd0);
        send_vector(16'sd32767, 16'sd0);
        send_vector(-16'sd32768, 16'sd0);
        send_vector(16'sd0, 16'sd1);
        send_vector(16'sd0, -16'sd1);
        send_vector(16'sd0, 16'sd32767);
        send_vector(16'sd0, -16'sd32768);
        send_vector(16'sd100, 16'sd100);
        send_vector(16'sd100, -16'sd100);
        send_vector(-16'sd100, 16'sd100);
        send_vector(-16'sd100, -16'sd100);
        send_vector(-16'sd32768, -16'sd32768);
        send_vector(-16'sd32768, 16'sd32767);
        send_vector(16'sd32767, -16'sd32768);
        send_vector(16'sd1, -16'sd32768);
        send_vector(-16'sd32768, 16'sd1);
        send_vector(16'sd1, 16'sd32767);
        send_vector(-16'sd1, -16'sd32767);
        send_vector(16'sd32767, 16'sd32766);
        send_vector(-16'sd21846, 16'sd16384);
        send_vector(16'sd12345, -16'sd20000);
    endtask

    // Random vectors with extra weight on diagonals and mirrored pairs
    task automatic test_random_mixed(input int unsigned count);
        logic signed [IW-1:0] y, x;
        repeat (count) begin
            y = random_component();
            case ($urandom_range(0, 5))
                0: x = IW'(y + (int'($urandom_range(0, 4)) - 2));
                1: x = -y;
                default: x = random_component();
            endcase
            if ($urandom_range(0, 1))
                send_vector(y, x);
            else
                send_vector(x, y);
        end
    endtask

    // Batches separated by a full drain of the pipe
    task automatic test_drain_pause();
        repeat (4) begin
            test_random_mixed(50);
            i_valid <= 1'b0;
            wait_all_angles();
        end
    endtask

    // Closing stream with no idling on either side
    task automatic test_streaming();
        idling_on = 1'b0;
        test_random_mixed(300);
    endtask

    // Output side: compare each accepted word, then pick next stall value.
    // Handshake is judged on values from before the edge.
    always @(posedge i_clk) begin : result_check
        t_angle_item head;
        if (i_rst_n) begin
            if ($isunknown(o_valid)) begin
                $display("%0t o_valid unknown: expected 0 or 1, actual %b", $time, o_valid);
                mismatch_count++;
            end else if (o_valid && !i_stall) begin
                if (pending_angles.size() == 0) begin
                    $display("%0t unexpected angle word: expected none, actual %0d",
                             $time, o_angle);
                    mismatch_count++;
                end else begin
                    head = pending_angles.pop_front();
                    if (o_angle !== head.angle) begin
                        $display("%0t angle mismatch y=%0d x=%0d: expected %0d, actual %0d",
                                 $time, head.y, head.x, head.angle, o_angle);
                        mismatch_count++;
                    end
                end
            end
        end
        if (stall_left != 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        int unsigned waited;
        waited  = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_stall <= 1'b0;
        i_y     <= '0;
        i_x     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idling_on = 1'b1;
        test_directed();
        test_random_mixed(900);
        test_drain_pause();
        test_streaming();
        i_valid <= 1'b0;

        while (pending_angles.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pending_angles.size() != 0) begin
            $display("%0t missing angle words: expected 0 pending, actual %0d",
                     $time, pending_angles.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
